@@ rtl/utf16_to_utf8_transcoder_core_macros.svh @@
// Assertion macros shared by the transcoder RTL.
// Each property is sampled on the rising edge of clk and disabled while rst_n is low.
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH

`ifndef SYNTH

`define UTX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transcoder check failed in the same cycle");

`define UTX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transcoder check failed in the following cycle");

`else

`define UTX_ASSERT_SAME(label, ante, cons)

`define UTX_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/utx_pkg.sv @@
`default_nettype none

package utx_pkg;

    localparam int UNIT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int MAX_BYTES = 4;
    localparam int COUNT_W = 3;
    localparam int IDX_W   = 2;

    // Upper six bits of a code unit that mark the two surrogate halves.
    localparam logic [5:0] LEAD_PREFIX  = 6'b110110;
    localparam logic [5:0] TRAIL_PREFIX = 6'b110111;

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [CP_W-1:0] CP_SPACE  = 21'h00020;
    localparam logic [CP_W-1:0] CP_DELETE = 21'h0007F;
    localparam logic [CP_W-1:0] CP_TWO    = 21'h00080;
    localparam logic [CP_W-1:0] CP_THREE  = 21'h00800;

    localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MARK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MARK = 8'hF0;

    typedef logic [UNIT_W-1:0] unit_t;

    // Encoded bytes of one code point, first byte in slot 0.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]               count;
    } group_t;

    function automatic logic is_lead(input unit_t unit);
        return unit[15:10] == LEAD_PREFIX;
    endfunction

    function automatic logic is_trail(input unit_t unit);
        return unit[15:10] == TRAIL_PREFIX;
    endfunction

endpackage

`default_nettype wire

@@ rtl/utx_unit_if.sv @@
`default_nettype none

interface utx_unit_if;
    logic                   valid;
    logic                   ready;
    logic [15:0]            code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

`default_nettype wire

@@ rtl/utx_byte_if.sv @@
`default_nettype none

interface utx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/utx_encode.sv @@
`default_nettype none

module utx_encode (
    input  wire utx_pkg::unit_t  unit,
    input  wire utx_pkg::unit_t  lead,
    output utx_pkg::group_t      group
);
    import utx_pkg::*;

    logic            unit_lead;
    logic            unit_trail;
    logic            suppress;
    logic [CP_W-1:0] cp;

    always_comb
    begin
        unit_lead  = is_lead(unit);
        unit_trail = is_trail(unit);

        // A held leading surrogate always lies in D800..DBFF, so its low ten bits
        // are the high half of the supplementary offset.
        if (unit_trail)
        begin
            cp = SUPP_BASE + {1'b0, lead[9:0], unit[9:0]};
        end
        else
        begin
            cp = {{(CP_W-UNIT_W){1'b0}}, unit};
        end

        suppress = unit_lead || (unit_trail && (lead == '0)) ||
                   (cp < CP_SPACE) || (cp == CP_DELETE);

        group.bytes = '0;
        group.count = '0;
        if (!suppress)
        begin
            if (cp < CP_TWO)
            begin
                group.bytes[0] = cp[7:0];
                group.count    = 3'd1;
            end
            else if (cp < CP_THREE)
            begin
                group.bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
                group.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
                group.count    = 3'd2;
            end
            else if (cp < SUPP_BASE)
            begin
                group.bytes[0] = LEAD3_MARK | {4'b0000, cp[15:12]};
                group.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
                group.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
                group.count    = 3'd3;
            end
            else
            begin
                group.bytes[0] = LEAD4_MARK | {5'b00000, cp[20:18]};
                group.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
                group.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
                group.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
                group.count    = 3'd4;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf16_to_utf8_transcoder_core.sv @@
// UTF-16 to UTF-8 transcoder.
// unit_ch carries one 16-bit UTF-16 code unit per transaction; byte_ch returns the
// UTF-8 encoding one byte per transaction, with last_of_run set on the final byte
// of each code point. Surrogate pairs are joined, stray surrogates, C0 control
// code points (below 20h) and DEL (7Fh) give no bytes.
// Each code unit is registered in the input register, encoded, and its bytes are
// then loaded into the byte serializer, which offers them on byte_ch. A code point
// holds the serializer until its last byte is taken, so the sustained rate is set by
// the single byte-wide output; units that yield nothing leave the serializer empty.
// The input register takes one new unit while the serializer still sends the
// previous code point, so back-to-back units see no extra bubble.
// Reset clears the held leading surrogate and empties both stages.
// When the receiver holds ready low, the current byte is kept on byte_ch, the
// input register fills, and unit_ch.ready then stays low until the last byte of
// the code point in the serializer is taken.
`default_nettype none
`include "utf16_to_utf8_transcoder_core_macros.svh"

module utf16_to_utf8_transcoder_core (
    input  wire       clk,
    input  wire       rst_n,
    utx_unit_if.sink  unit_ch,
    utx_byte_if.source byte_ch
);
    import utx_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    unit_t              s1_unit_reg;
    unit_t              s1_lead_reg;
    unit_t              held_reg;
    unit_t              held_next;

    logic               ser_valid_reg;
    logic               ser_valid_next;
    group_t             ser_group_reg;
    group_t             ser_group_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    group_t             enc_group;
    logic               in_take;
    logic               out_take;
    logic               last_byte;
    logic               ser_free;
    logic               s1_fire;

    utx_encode u_encode (
        .unit  (s1_unit_reg),
        .lead  (s1_lead_reg),
        .group (enc_group)
    );

    assign last_byte = ({1'b0, idx_reg} == (ser_group_reg.count - 3'd1));
    assign out_take  = byte_ch.valid && byte_ch.ready;
    assign ser_free  = !ser_valid_reg || (out_take && last_byte);
    assign s1_fire   = s1_valid_reg && ser_free;
    assign in_take   = unit_ch.valid && unit_ch.ready;

    assign unit_ch.ready       = !s1_valid_reg || ser_free;
    assign byte_ch.valid       = ser_valid_reg;
    assign byte_ch.out_byte    = ser_group_reg.bytes[idx_reg];
    assign byte_ch.last_of_run = last_byte;

    always_comb
    begin
        held_next = held_reg;
        if (in_take)
        begin
            held_next = is_lead(unit_ch.code_unit) ? unit_ch.code_unit : '0;
        end

        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        ser_valid_next = ser_valid_reg;
        ser_group_next = ser_group_reg;
        idx_next       = idx_reg;
        if (s1_fire)
        begin
            // A code unit that encodes to nothing just leaves the serializer empty.
            ser_valid_next = (enc_group.count != '0);
            ser_group_next = enc_group;
            idx_next       = '0;
        end
        else if (out_take && last_byte)
        begin
            ser_valid_next = 1'b0;
        end
        else if (out_take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            held_reg      <= held_next;
            s1_valid_reg  <= s1_valid_next;
            ser_valid_reg <= ser_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_unit_reg <= unit_ch.code_unit;
            s1_lead_reg <= held_reg;
        end
        ser_group_reg <= ser_group_next;
    end

    `UTX_ASSERT_SAME(a_count_range, ser_valid_reg,
        (ser_group_reg.count != 3'd0) && (ser_group_reg.count <= 3'd4))
    `UTX_ASSERT_SAME(a_idx_in_group, ser_valid_reg, ({1'b0, idx_reg} < ser_group_reg.count))
    `UTX_ASSERT_NEXT(a_last_empties, out_take && last_byte && !s1_valid_reg, !ser_valid_reg)
    `UTX_ASSERT_NEXT(a_lead_held, in_take && is_lead(unit_ch.code_unit), held_reg != '0)
    `UTX_ASSERT_NEXT(a_stall_blocks_input, s1_valid_reg && ser_valid_reg && !byte_ch.ready,
        s1_valid_reg)

endmodule

`default_nettype wire
